### rtl/glzw_pkg.sv
package glzw_pkg;

  localparam int TABLE_SIZE     = 4096;
  localparam int STACK_DEPTH    = 4096;
  localparam int MAX_CODE_WIDTH = 12;
  localparam int TAB_AW         = $clog2(TABLE_SIZE);
  localparam int STK_AW         = $clog2(STACK_DEPTH);

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_PULL  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [2:0] ST_PIXEL   = 3'd0;
  localparam logic [2:0] ST_TAKEN   = 3'd1;
  localparam logic [2:0] ST_REFUSED = 3'd2;
  localparam logic [2:0] ST_NEED    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_ERROR   = 3'd5;

  localparam logic [0:0] REG_MIN_CODE_SIZE = 1'd0;
  localparam logic [0:0] REG_PIXEL_LIMIT   = 1'd1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pixel;
    logic [19:0] pixel_count;
  } out_item_t;

  // Effective minimum code size after clamping to the table and width limits.
  function automatic logic [3:0] eff_min(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (r < 4'd2) r = 4'd2;
    if (r > 4'd11) r = 4'd11;
    for (int k = 0; k < 10; k++) begin
      if (r > 4'd2 && (((32'd1 << r) + 32'd2) > TABLE_SIZE ||
                       (32'(r) + 32'd1) > MAX_CODE_WIDTH)) begin
        r = r - 4'd1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/gif_lzw_decoder.sv
// GIF LZW decoder, variable code width, codes packed LSB first.
// Input channel (in_valid/in_stall/in_data) carries one command per
// transaction: push a compressed byte, pull one pixel, or start a frame.
// Output channel (out_valid/out_stall/out_data) returns exactly one result
// per command: status, pixel and the running pixel count.
// Configuration: cfg_we/cfg_index/cfg_data writes min_code_size (0) or
// pixel_limit (1); write only while the block is idle.
// Push, start and unused commands present their result in the cycle after
// acceptance. A pull that finds nothing to do passes S_PULL and S_FIN; a
// pull that pops the stack passes S_PULL, S_POP and S_WAIT (a registered
// memory read). Decoding a code adds S_CODE, then S_READ and S_WALK per chain
// step (one dictionary read each), amortized over the pixels that code yields.
// One command is worked on at a time; in_stall is high while busy or while
// a result waits, so a new command is taken only once the result is accepted.
// A stalled result holds in the output register.
// Reset (and each start command) runs a clearing pass over all 4096 entries
// of the suffix store, during which no command is accepted.
module gif_lzw_decoder import glzw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PULL  = 8'b00000010,
    S_POP   = 8'b00000100,
    S_CODE  = 8'b00001000,
    S_WALK  = 8'b00010000,
    S_WAIT  = 8'b00100000,
    S_FIN   = 8'b01000000,
    S_READ  = 8'b10000000
  } state_t;

  state_t state;

  logic [3:0]  min_code_size;
  logic [19:0] pixel_limit;

  logic [31:0] bit_buffer;
  logic [5:0]  bit_count;
  logic [3:0]  code_width;
  logic [12:0] next_free_code;
  logic [11:0] previous_code;
  logic        previous_valid;
  logic [7:0]  first_symbol;
  logic [12:0] stack_pointer;
  logic [19:0] emitted_count;
  logic        input_ended;
  logic        decode_finished;
  logic        decode_error;

  logic [11:0] code;
  logic [12:0] chain;
  logic [7:0]  pop_pixel;

  logic              clr_start, clr_busy;
  logic [TAB_AW-1:0] d_rd_addr;
  logic [11:0]       d_prefix;
  logic [7:0]        d_suffix;
  logic              d_wr_en;

  logic              s_wr_en;
  logic [STK_AW-1:0] s_wr_addr;
  logic [7:0]        s_wr_data;
  logic [7:0]        s_rd_data;

  logic [3:0]  em;
  logic [12:0] clear_code, eoi_code;
  logic [11:0] width_mask;

  assign em         = eff_min(min_code_size);
  assign clear_code = 13'd1 << em;
  assign eoi_code   = clear_code + 13'd1;
  assign width_mask = 12'((13'd1 << code_width) - 13'd1);

  assign in_stall = (state != S_IDLE) || out_valid || clr_busy;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size <= 4'd8;
      pixel_limit   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MIN_CODE_SIZE) min_code_size <= cfg_data[3:0];
      if (cfg_index == REG_PIXEL_LIMIT)   pixel_limit   <= cfg_data;
    end
  end

  glzw_dict u_dict (
    .clk       (clk),
    .rst       (rst),
    .clr_start (clr_start),
    .clr_busy  (clr_busy),
    .rd_addr   (d_rd_addr),
    .rd_prefix (d_prefix),
    .rd_suffix (d_suffix),
    .wr_en     (d_wr_en),
    .wr_addr   (next_free_code[TAB_AW-1:0]),
    .wr_prefix (previous_code),
    .wr_suffix (chain[7:0])
  );

  glzw_stack u_stack (
    .clk     (clk),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_data (s_wr_data),
    .rd_addr (STK_AW'(stack_pointer - 13'd1)),
    .rd_data (pop_pixel)
  );
  assign s_rd_data = pop_pixel;

  assign d_rd_addr = chain[TAB_AW-1:0];
  assign clr_start = (state == S_IDLE) && in_valid && !in_stall &&
                     in_data.func == FUNC_START;

  // Stack write and dictionary write decoded from the current step
  logic        walk_push, walk_ovf, walk_bad, walk_root;
  always_comb begin
    walk_root = chain <= eoi_code;
    walk_bad  = !walk_root && chain >= 13'(TABLE_SIZE);
    walk_ovf  = stack_pointer >= 13'(STACK_DEPTH);
    walk_push = (state == S_WALK) && !walk_bad && !walk_ovf;
    s_wr_en   = walk_push || (state == S_CODE && code == next_free_code[11:0] &&
                next_free_code[12] == 1'b0 && previous_valid && !walk_ovf &&
                code != clear_code[11:0] && code != eoi_code[11:0]);
    s_wr_addr = stack_pointer[STK_AW-1:0];
    s_wr_data = (state == S_WALK) ? (walk_root ? chain[7:0] : d_suffix) : first_symbol;
    d_wr_en   = walk_push && walk_root && previous_valid &&
                next_free_code < 13'(TABLE_SIZE);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      bit_buffer      <= '0;
      bit_count       <= '0;
      code_width      <= 4'd9;
      next_free_code  <= 13'd258;
      previous_code   <= '0;
      previous_valid  <= 1'b0;
      first_symbol    <= '0;
      stack_pointer   <= '0;
      emitted_count   <= '0;
      input_ended     <= 1'b0;
      decode_finished <= 1'b0;
      decode_error    <= 1'b0;
      chain           <= '0;
      code            <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            out_data.pixel       <= '0;
            out_data.pixel_count <= (in_data.func == FUNC_START) ? 20'd0 : emitted_count;
            case (in_data.func)
              FUNC_PUSH: begin
                if (bit_count > 6'd24) begin
                  out_data.status <= ST_REFUSED;
                end else begin
                  bit_buffer      <= bit_buffer | (32'(in_data.data_byte) << bit_count);
                  bit_count       <= bit_count + 6'd8;
                  if (in_data.last_byte) input_ended <= 1'b1;
                  out_data.status <= ST_TAKEN;
                end
                out_valid <= 1'b1;
              end
              FUNC_PULL: state <= S_PULL;
              FUNC_START: begin
                bit_buffer      <= '0;
                bit_count       <= '0;
                stack_pointer   <= '0;
                emitted_count   <= '0;
                first_symbol    <= '0;
                input_ended     <= 1'b0;
                decode_finished <= 1'b0;
                decode_error    <= 1'b0;
                code_width      <= em + 4'd1;
                next_free_code  <= clear_code + 13'd2;
                previous_code   <= '0;
                previous_valid  <= 1'b0;
                out_data.status <= ST_NEED;
                out_valid       <= 1'b1;
              end
              default: begin
                out_data.status <= decode_error ? ST_ERROR :
                                   decode_finished ? ST_DONE : ST_NEED;
                out_valid       <= 1'b1;
              end
            endcase
          end
        end
        // One iteration of the pull loop
        S_PULL: begin
          if (decode_error) begin
            out_data.status <= ST_ERROR;
            state <= S_FIN;
          end else if (stack_pointer != 13'd0 && emitted_count < pixel_limit) begin
            state <= S_POP;
          end else if (decode_finished) begin
            stack_pointer   <= '0;
            out_data.status <= ST_DONE;
            state <= S_FIN;
          end else if (bit_count < 6'(code_width)) begin
            stack_pointer <= '0;
            if (input_ended) begin
              decode_finished <= 1'b1;
              out_data.status <= ST_DONE;
            end else begin
              out_data.status <= ST_NEED;
            end
            state <= S_FIN;
          end else begin
            stack_pointer <= '0;
            code       <= bit_buffer[11:0] & width_mask;
            bit_buffer <= bit_buffer >> code_width;
            bit_count  <= bit_count - 6'(code_width);
            state      <= S_CODE;
          end
        end
        // Stack read issued last cycle lands now
        S_POP: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          stack_pointer        <= stack_pointer - 13'd1;
          emitted_count        <= emitted_count + 20'd1;
          out_data.status      <= ST_PIXEL;
          out_data.pixel       <= s_rd_data;
          out_data.pixel_count <= emitted_count + 20'd1;
          out_valid            <= 1'b1;
          state                <= S_IDLE;
        end
        S_CODE: begin
          if (13'(code) == clear_code) begin
            code_width     <= em + 4'd1;
            next_free_code <= clear_code + 13'd2;
            previous_code  <= '0;
            previous_valid <= 1'b0;
            state <= S_PULL;
          end else if (13'(code) == eoi_code) begin
            decode_finished <= 1'b1;
            state <= S_PULL;
          end else if (13'(code) == next_free_code) begin
            if (!previous_valid) begin
              decode_error <= 1'b1;
              state <= S_PULL;
            end else begin
              stack_pointer <= 13'd1;
              chain <= 13'(previous_code);
              state <= S_READ;
            end
          end else if (13'(code) > next_free_code) begin
            decode_error <= 1'b1;
            state <= S_PULL;
          end else begin
            chain <= 13'(code);
            state <= S_READ;
          end
        end
        // Dictionary read of chain is in flight
        S_READ: begin
          state <= S_WALK;
        end
        // One chain step per visit: dictionary data for chain was read in
        // the cycle before, so each step is WALK after a read settles
        S_WALK: begin
          if (walk_bad || walk_ovf) begin
            decode_error  <= 1'b1;
            stack_pointer <= '0;
            state <= S_PULL;
          end else if (walk_root) begin
            stack_pointer <= stack_pointer + 13'd1;
            first_symbol  <= chain[7:0];
            if (previous_valid && next_free_code < 13'(TABLE_SIZE)) begin
              next_free_code <= next_free_code + 13'd1;
              if ((next_free_code + 13'd1) == (13'd1 << code_width) &&
                  code_width < 4'(MAX_CODE_WIDTH))
                code_width <= code_width + 4'd1;
            end
            previous_code  <= code;
            previous_valid <= 1'b1;
            state <= S_PULL;
          end else begin
            stack_pointer <= stack_pointer + 13'd1;
            chain <= 13'(d_prefix);
            state <= S_READ;
          end
        end
        S_FIN: begin
          out_data.pixel       <= '0;
          out_data.pixel_count <= emitted_count;
          out_valid            <= 1'b1;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/glzw_dict.sv
module glzw_dict import glzw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // clearing sweep of the suffix store
  input  logic              clr_start,
  output logic              clr_busy,
  // read port
  input  logic [TAB_AW-1:0] rd_addr,
  output logic [11:0]       rd_prefix,
  output logic [7:0]        rd_suffix,
  // write port
  input  logic              wr_en,
  input  logic [TAB_AW-1:0] wr_addr,
  input  logic [11:0]       wr_prefix,
  input  logic [7:0]        wr_suffix
);

  logic [11:0] prefix_mem [TABLE_SIZE];
  logic [7:0]  suffix_mem [TABLE_SIZE];
  logic [TAB_AW-1:0] clr_addr;

  // Sweep the suffix store back to roots, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_start) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + TAB_AW'(1);
      if (clr_addr == TAB_AW'(TABLE_SIZE - 1)) clr_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      suffix_mem[clr_addr] <= clr_addr[7:0];
    end else if (wr_en) begin
      suffix_mem[wr_addr] <= wr_suffix;
    end
    if (wr_en && !clr_busy) prefix_mem[wr_addr] <= wr_prefix;
    rd_prefix <= prefix_mem[rd_addr];
    rd_suffix <= suffix_mem[rd_addr];
  end

endmodule

### rtl/glzw_stack.sv
module glzw_stack import glzw_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [STK_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [STK_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule
